/* hdl/pre_pkg.sv */
package pre_pkg;

   // Character codes used by the printable test and the run terminator
   localparam logic [7:0] CharTab       = 8'h09;
   localparam logic [7:0] CharNewline   = 8'h0A;
   localparam logic [7:0] PrintLow      = 8'h20;
   localparam logic [7:0] PrintHigh     = 8'h7E;

   // Defaults for the top-level parameters
   localparam int MinRunDefault     = 4;
   localparam int QueueDepthDefault = 4;

   // Input item
   typedef struct packed {
      logic [7:0] in_byte;
      logic       end_of_dump;
   } req_type;

   // Result item
   typedef struct packed {
      logic [7:0] out_byte;
      logic       burst_last;
   } rsp_type;

   // Job queue status seen by the front and back parts
   typedef struct packed {
      logic not_empty;
      logic full;
   } queue_status_type;

   // Printable test: 0x20..0x7E, tab or newline
   function automatic logic is_printable(input logic [7:0] c);
      return (c == CharNewline) || (c == CharTab) || ((c >= PrintLow) && (c <= PrintHigh));
   endfunction

endpackage

/* hdl/pre_front.sv */
module pre_front #(
   parameter int MIN_RUN = pre_pkg::MinRunDefault
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   input  pre_pkg::req_type            req_data,
   output logic                        req_stall,
   input  pre_pkg::queue_status_type   queue_status,
   output logic                        job_push,
   output logic [MIN_RUN-1:0][7:0]     job_bytes,
   output logic [$clog2(MIN_RUN+1)-1:0] job_count,
   output logic                        job_newline
);

   localparam int RunW     = $clog2(MIN_RUN + 1);
   localparam int Hold     = (MIN_RUN > 1) ? MIN_RUN - 1 : 1;
   localparam int HeldIdxW = (Hold > 1) ? $clog2(Hold) : 1;
   localparam logic [RunW:0] MinRunExt = (RunW + 1)'(MIN_RUN);

   logic [Hold-1:0][7:0] held_ff;
   logic [RunW-1:0]      run_len_ff, run_len_in;
   logic                 prev_nl_ff, prev_nl_in;

   logic       accept;
   logic       printable;
   logic       is_nl;
   logic [RunW:0] run_next;
   logic       hold_byte;
   logic       flush_run;

   // Transfer takes place whenever the queue has room
   assign req_stall = queue_status.full;
   assign accept    = req_valid && !queue_status.full;

   assign printable = pre_pkg::is_printable(req_data.in_byte);
   assign is_nl     = (req_data.in_byte == pre_pkg::CharNewline);
   assign run_next  = {1'b0, run_len_ff} + (RunW + 1)'(1);
   assign hold_byte = printable && (run_next < MinRunExt);
   assign flush_run = printable && (run_next == MinRunExt);

   // Classify the byte into a job: bytes to emit and whether a newline closes the run
   always_comb begin
      logic [RunW-1:0] len_after;
      len_after   = run_len_ff;
      run_len_in  = run_len_ff;
      prev_nl_in  = prev_nl_ff;
      job_count   = '0;
      job_newline = 1'b0;
      job_bytes   = '0;
      for (int i = 0; i < Hold; i++) begin
         job_bytes[i] = held_ff[i];
      end
      job_bytes[MIN_RUN-1] = req_data.in_byte;

      if (printable) begin
         if (hold_byte) begin
            len_after = run_next[RunW-1:0];
         end else if (flush_run) begin
            job_count = RunW'(MIN_RUN);
            len_after = RunW'(MIN_RUN);
         end else begin
            job_bytes[0] = req_data.in_byte;
            job_count    = RunW'(1);
         end
         if (req_data.end_of_dump) begin
            job_newline = ({1'b0, len_after} >= MinRunExt) && !is_nl;
            run_len_in  = '0;
            prev_nl_in  = 1'b0;
         end else begin
            run_len_in  = len_after;
            prev_nl_in  = is_nl;
         end
      end else begin
         // Break: close a kept run, drop a short one
         job_newline = ({1'b0, run_len_ff} >= MinRunExt) && !prev_nl_ff;
         run_len_in  = '0;
         prev_nl_in  = 1'b0;
      end
   end

   assign job_push = accept && ((job_count != '0) || job_newline);

   // Run state
   always_ff @(posedge clock) begin
      if (reset) begin
         run_len_ff <= '0;
         prev_nl_ff <= 1'b0;
      end else if (accept) begin
         run_len_ff <= run_len_in;
         prev_nl_ff <= prev_nl_in;
      end
   end

   // Held bytes of a run not yet long enough
   always_ff @(posedge clock) begin
      if (accept && hold_byte) begin
         held_ff[run_len_ff[HeldIdxW-1:0]] <= req_data.in_byte;
      end
   end

endmodule

/* hdl/pre_queue.sv */
module pre_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = pre_pkg::QueueDepthDefault
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   input  logic [WIDTH-1:0]          push_data,
   input  logic                      pop,
   output logic [WIDTH-1:0]          pop_data,
   output pre_pkg::queue_status_type status
);

   localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CntW = $clog2(DEPTH + 1);
   localparam logic [PtrW-1:0] LastPtr = PtrW'(DEPTH - 1);
   localparam logic [CntW-1:0] FullCnt = CntW'(DEPTH);

   logic [WIDTH-1:0] entry_ff [DEPTH];
   logic [PtrW-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0]  count_ff, count_in;
   logic             do_push, do_pop;

   assign status.full      = (count_ff == FullCnt);
   assign status.not_empty = (count_ff != '0);
   assign do_push          = push && !status.full;
   assign do_pop           = pop && status.not_empty;
   assign pop_data         = entry_ff[rd_ptr_ff];

   // Pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LastPtr) ? '0 : wr_ptr_ff + PtrW'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LastPtr) ? '0 : rd_ptr_ff + PtrW'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CntW'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CntW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   // Fill count never passes the depth
   assert property (@(posedge clock) disable iff (reset) count_ff <= FullCnt)
      else $error("job queue overfilled");

   // Pointers agree with the fill count
   assert property (@(posedge clock) disable iff (reset)
      (count_ff == '0 || count_ff == FullCnt) |-> (wr_ptr_ff == rd_ptr_ff))
      else $error("job queue pointers disagree with count");

   // A pop without a push frees exactly one entry
   assert property (@(posedge clock) disable iff (reset)
      (do_pop && !do_push) |=> (count_ff == $past(count_ff) - CntW'(1)))
      else $error("job queue count wrong after pop");

endmodule

/* hdl/pre_back.sv */
module pre_back #(
   parameter int MIN_RUN = pre_pkg::MinRunDefault
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         job_valid,
   input  logic [MIN_RUN-1:0][7:0]      job_bytes,
   input  logic [$clog2(MIN_RUN+1)-1:0] job_count,
   input  logic                         job_newline,
   output logic                         job_pop,
   output logic                         rsp_valid,
   output pre_pkg::rsp_type             rsp_data,
   input  logic                         rsp_stall
);

   localparam int IdxW     = $clog2(MIN_RUN + 1);
   localparam int ByteIdxW = (MIN_RUN > 1) ? $clog2(MIN_RUN) : 1;

   logic [IdxW-1:0]  idx_ff, idx_in;
   logic             rsp_valid_ff, rsp_valid_in;
   pre_pkg::rsp_type rsp_ff, rsp_in;

   logic          advance;
   logic [IdxW:0] total;
   logic          last_of_job;

   // Output register frees up when empty or taken
   assign advance     = !rsp_valid_ff || !rsp_stall;
   assign total       = {1'b0, job_count} + (IdxW + 1)'(job_newline);
   assign last_of_job = (({1'b0, idx_ff} + (IdxW + 1)'(1)) == total);
   assign job_pop     = advance && job_valid && last_of_job;

   // Pick the next result of the head job
   always_comb begin
      idx_in       = idx_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (advance) begin
         rsp_valid_in = job_valid;
         if (job_valid) begin
            rsp_in.out_byte   = (idx_ff < job_count) ? job_bytes[idx_ff[ByteIdxW-1:0]]
                                                     : pre_pkg::CharNewline;
            rsp_in.burst_last = last_of_job;
            idx_in            = last_of_job ? '0 : idx_ff + IdxW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // Index stays inside the head job
   assert property (@(posedge clock) disable iff (reset)
      job_valid |-> ({1'b0, idx_ff} < total))
      else $error("result index beyond job");

   // Index returns to zero once a job is popped
   assert property (@(posedge clock) disable iff (reset) job_pop |=> (idx_ff == '0))
      else $error("result index not cleared after pop");

   // Last result of a job always goes with a pop
   assert property (@(posedge clock) disable iff (reset)
      (advance && job_valid && last_of_job) |=> (rsp_valid_ff && rsp_ff.burst_last))
      else $error("burst end lost");

endmodule

/* hdl/printable_run_extractor_unit.sv */
// Each job is stored in a queue entry; the back part puts its results in an output register,
// which holds each one while the receiver stalls.
// Throughput: one input byte per cycle while the job queue has room; the back part emits one
// result per cycle unless stalled; a job expands into a burst of up to MIN_RUN+1 results.
// Queue depth (QUEUE_DEPTH jobs) absorbs those bursts; items without results take no entry.
// Reset (synchronous, active high) empties the queue, clears run length and newline flag.
module printable_run_extractor_unit #(
   parameter int MIN_RUN     = pre_pkg::MinRunDefault,
   parameter int QUEUE_DEPTH = pre_pkg::QueueDepthDefault
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  pre_pkg::req_type req_data,
   output logic             req_stall,
   output logic             rsp_valid,
   output pre_pkg::rsp_type rsp_data,
   input  logic             rsp_stall
);

   localparam int CntW   = $clog2(MIN_RUN + 1);
   localparam int EntryW = MIN_RUN * 8 + CntW + 1;

   pre_pkg::queue_status_type queue_status;

   logic                    job_push;
   logic [MIN_RUN-1:0][7:0] push_bytes;
   logic [CntW-1:0]         push_count;
   logic                    push_newline;
   logic [EntryW-1:0]       push_entry;

   logic                    job_pop;
   logic [EntryW-1:0]       head_entry;
   logic [MIN_RUN-1:0][7:0] head_bytes;
   logic [CntW-1:0]         head_count;
   logic                    head_newline;

   // Front: classify and track runs
   pre_front #(
      .MIN_RUN (MIN_RUN)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_data     (req_data),
      .req_stall    (req_stall),
      .queue_status (queue_status),
      .job_push     (job_push),
      .job_bytes    (push_bytes),
      .job_count    (push_count),
      .job_newline  (push_newline)
   );

   assign push_entry = {push_bytes, push_count, push_newline};

   // Job queue between front and back
   pre_queue #(
      .WIDTH (EntryW),
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (job_push),
      .push_data (push_entry),
      .pop       (job_pop),
      .pop_data  (head_entry),
      .status    (queue_status)
   );

   assign {head_bytes, head_count, head_newline} = head_entry;

   // Back: expand jobs into result bytes
   pre_back #(
      .MIN_RUN (MIN_RUN)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .job_valid   (queue_status.not_empty),
      .job_bytes   (head_bytes),
      .job_count   (head_count),
      .job_newline (head_newline),
      .job_pop     (job_pop),
      .rsp_valid   (rsp_valid),
      .rsp_data    (rsp_data),
      .rsp_stall   (rsp_stall)
   );

endmodule

/* verif/printable_run_extractor_unit_tb.sv */
module printable_run_extractor_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int MinRun     = pre_pkg::MinRunDefault;
   localparam int TailCycles = 10;
   localparam int StuckLimit = 2000;

   logic             clock     = 1'b0;
   logic             reset     = 1'b1;
   logic             req_valid = 1'b0;
   pre_pkg::req_type req_data  = '0;
   logic             req_stall;
   logic             rsp_valid;
   pre_pkg::rsp_type rsp_data;
   logic             rsp_stall = 1'b0;

   printable_run_extractor_unit #(
      .MIN_RUN (MinRun)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_data  (req_data),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .rsp_stall (rsp_stall)
   );

   always #1 clock = ~clock;

   // Transfer flags and result payload, settled at the falling edge
   bit               req_fire_s;
   bit               rsp_fire_s;
   pre_pkg::rsp_type rsp_seen;

   always @(negedge clock) begin
      req_fire_s = req_valid && !req_stall;
      rsp_fire_s = rsp_valid && !rsp_stall;
      rsp_seen   = rsp_data;
   end

   // Run tracker: its own copy of the block's state
   logic [7:0]       run_head [MinRun];
   int unsigned      run_count = 0;
   bit               run_ends_nl = 1'b0;
   pre_pkg::rsp_type burst_bytes [$];
   pre_pkg::rsp_type expected_bytes [$];
   int               error_count = 0;
   bit               idle_on = 1'b0;

   function automatic bit is_text_byte(input logic [7:0] c);
      if (c == pre_pkg::CharTab || c == pre_pkg::CharNewline)
         return 1'b1;
      return (c >= pre_pkg::PrintLow) && (c <= pre_pkg::PrintHigh);
   endfunction

   function automatic void emit_byte(input logic [7:0] b);
      pre_pkg::rsp_type r;
      r.out_byte   = b;
      r.burst_last = 1'b0;
      burst_bytes.push_back(r);
   endfunction

   // A kept run that ends gets a newline unless it already ends in one
   function automatic void end_run();
      if (run_count >= MinRun && !run_ends_nl)
         emit_byte(pre_pkg::CharNewline);
      run_count   = 0;
      run_ends_nl = 1'b0;
   endfunction

   function automatic void track_run(input pre_pkg::req_type item);
      if (is_text_byte(item.in_byte)) begin
         if (run_count + 1 < MinRun) begin
            run_head[run_count] = item.in_byte;
            run_count++;
         end else if (run_count + 1 == MinRun) begin
            for (int i = 0; i < MinRun - 1; i++)
               emit_byte(run_head[i]);
            emit_byte(item.in_byte);
            run_count = MinRun;
         end else begin
            emit_byte(item.in_byte);
         end
         run_ends_nl = (item.in_byte == pre_pkg::CharNewline);
         if (item.end_of_dump)
            end_run();
      end else begin
         end_run();
      end
      if (burst_bytes.size() > 0)
         burst_bytes[burst_bytes.size() - 1].burst_last = 1'b1;
      foreach (burst_bytes[i])
         expected_bytes.push_back(burst_bytes[i]);
      burst_bytes.delete();
   endfunction

   // Result checker
   always @(posedge clock) begin
      pre_pkg::rsp_type want;
      if (rsp_fire_s) begin
         if (expected_bytes.size() == 0) begin
            $display("%0t: unexpected result: expected none, actual byte %h last %b",
                     $time, rsp_seen.out_byte, rsp_seen.burst_last);
            error_count++;
         end else begin
            want = expected_bytes.pop_front();
            if (rsp_seen.out_byte !== want.out_byte) begin
               $display("%0t: out_byte mismatch: expected %h, actual %h",
                        $time, want.out_byte, rsp_seen.out_byte);
               error_count++;
            end
            if (rsp_seen.burst_last !== want.burst_last) begin
               $display("%0t: burst_last mismatch: expected %b, actual %b",
                        $time, want.burst_last, rsp_seen.burst_last);
               error_count++;
            end
         end
      end
   end

   // Receiver stall bursts
   int stall_left = 0;

   always @(posedge clock) begin
      if (idle_on && stall_left == 0 && $urandom_range(0, 5) == 0)
         stall_left = $urandom_range(1, 17);
      if (stall_left > 0) begin
         rsp_stall <= 1'b1;
         stall_left--;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // Watchdog on cycles without any transfer
   int quiet_cycles = 0;

   always @(posedge clock) begin
      if (req_fire_s || rsp_fire_s)
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= StuckLimit) begin
         $display("%0t: no transfer for %0d cycles", $time, StuckLimit);
         $display("** printable_run_extractor_unit: FAILED **");
         $finish;
      end
   end

   // One input transfer; valid stays high for a back-to-back follower
   task automatic send_item(input logic [7:0] b, input bit last);
      pre_pkg::req_type item;
      item.in_byte     = b;
      item.end_of_dump = last;
      if (idle_on && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 17)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (!req_fire_s);
      track_run(item);
   endtask

   task automatic wait_for_results();
      req_valid <= 1'b0;
      while (expected_bytes.size() > 0) @(posedge clock);
   endtask

   function automatic logic [7:0] pick_text_byte();
      unique case ($urandom_range(0, 9))
         0: return pre_pkg::CharTab;
         1: return pre_pkg::CharNewline;
         default: return 8'($urandom_range(pre_pkg::PrintLow, pre_pkg::PrintHigh));
      endcase
   endfunction

   function automatic logic [7:0] pick_binary_byte();
      logic [7:0] b;
      do b = 8'($urandom_range(0, 255)); while (is_text_byte(b));
      return b;
   endfunction

   // Run past the threshold, range edges, break on 0xFF
   task automatic test_long_run();
      send_item(pre_pkg::PrintLow, 1'b0);
      send_item(pre_pkg::PrintHigh, 1'b0);
      send_item("a", 1'b0);
      send_item("b", 1'b0);
      send_item("c", 1'b0);
      send_item(8'hFF, 1'b0);
   endtask

   // Run below the threshold is dropped at a break
   task automatic test_short_run_drop();
      send_item("a", 1'b0);
      send_item("b", 1'b0);
      send_item(8'h1F, 1'b0);
   endtask

   // Run ending in newline gets no second newline
   task automatic test_newline_close();
      send_item(pre_pkg::CharTab, 1'b0);
      send_item("x", 1'b0);
      send_item("y", 1'b0);
      send_item(pre_pkg::CharNewline, 1'b0);
      send_item(8'h7F, 1'b0);
   endtask

   // End marker closes a kept run, a short run and an empty one
   task automatic test_end_of_dump();
      send_item("a", 1'b0);
      send_item("b", 1'b0);
      send_item("c", 1'b0);
      send_item("d", 1'b1);
      send_item("q", 1'b0);
      send_item("r", 1'b1);
      send_item(8'h00, 1'b1);
   endtask

   // Non-printable bytes with no run open, next to the printable edges
   task automatic test_binary_noise();
      send_item(8'h08, 1'b0);
      send_item(8'h0B, 1'b0);
      send_item(8'h80, 1'b0);
   endtask

   // Runs of random text and length, closed by binary or end marker; some noise
   task automatic test_random_runs(input int count);
      int sent;
      int len;
      sent = 0;
      while (sent < count) begin
         if ($urandom_range(0, 7) == 0) begin
            send_item(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
            sent++;
         end else begin
            len = $urandom_range(0, 10);
            for (int i = 0; i < len; i++) begin
               send_item(pick_text_byte(),
                         (i == len - 1) && ($urandom_range(0, 3) == 0));
               sent++;
            end
            send_item(pick_binary_byte(), 1'($urandom_range(0, 4) == 0));
            sent++;
         end
      end
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_long_run();
      test_short_run_drop();
      test_newline_close();
      test_end_of_dump();
      test_binary_noise();

      idle_on = 1'b1;
      test_random_runs(150);
      wait_for_results();
      test_random_runs(150);
      idle_on = 1'b0;
      test_random_runs(100);

      wait_for_results();
      repeat (TailCycles) @(posedge clock);
      if (error_count == 0)
         $display("** printable_run_extractor_unit: PASSED **");
      else
         $display("** printable_run_extractor_unit: FAILED **");
      $finish;
   end

endmodule

/* filelist.f */
hdl/pre_pkg.sv
hdl/pre_front.sv
hdl/pre_queue.sv
hdl/pre_back.sv
hdl/printable_run_extractor_unit.sv
verif/printable_run_extractor_unit_tb.sv
